### rtl/sacrr_pkg.sv
// ----------------------------------------------------------------------------
// sacrr_pkg
// Constants, types and helpers shared by the set-associative cache with
// random replacement.
// ----------------------------------------------------------------------------
package sacrr_pkg;

  localparam int MAX_LINES   = 64;
  localparam int STORE_DEPTH = 2 * MAX_LINES;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int WAY_W       = $clog2(MAX_LINES);
  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 32;
  localparam int LFSR_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [3:0]        OFFSET_MAX = 4'd12;
  localparam logic [2:0]        LINES_MAX  = 3'(WAY_W);
  localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_LOG2       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2        = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FILL
  } state_e;

  // Galois step: shift right, fold taps in when a one drops out
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

### rtl/sacrr_req_if.sv
// ----------------------------------------------------------------------------
// sacrr_req_if
// Access channel: byte address and cache selector.
// ----------------------------------------------------------------------------
interface sacrr_req_if
  import sacrr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              cache_select;

  modport source (output valid, output address, output cache_select, input ready);
  modport sink   (input valid, input address, input cache_select, output ready);
endinterface

### rtl/sacrr_rsp_if.sv
// ----------------------------------------------------------------------------
// sacrr_rsp_if
// Result channel: hit/miss outcome, location and running totals.
// ----------------------------------------------------------------------------
interface sacrr_rsp_if
  import sacrr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [WAY_W-1:0] set_index;
  logic [WAY_W-1:0] way_used;
  logic             filled_empty;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;

  modport source (output valid, output hit, output set_index, output way_used,
                  output filled_empty, output hit_total, output miss_total,
                  input ready);
  modport sink   (input valid, input hit, input set_index, input way_used,
                  input filled_empty, input hit_total, input miss_total,
                  output ready);
endinterface

### rtl/sacrr_ram.sv
// ----------------------------------------------------------------------------
// sacrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/set_assoc_cache_random_replace_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_random_replace_top
// Instruction and data cache tag model with LFSR victim selection.
// ----------------------------------------------------------------------------
// One access is handled at a time. After the address transfer the block
// reads the tag store one way per cycle. It compares the previous read while
// it issues the next, and stops on the first hit. On a miss the cycle after
// the last compare picks and fills a way. The tag RAM has a single read
// port. The result sits in an output register. While an earlier result is
// still waiting there, the current access holds at its final step. A new
// access is taken in the cycle after the result is loaded, once the block is
// back in idle.
// Configuration writes take effect on the next access and do not flush.
module set_assoc_cache_random_replace_top
  import sacrr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sacrr_req_if.sink             req_i,
  sacrr_rsp_if.source           rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [3:0] boff_q;
  logic [2:0] lines_q;
  logic [2:0] ways_q;

  logic [ADDR_W-1:0] blk_q, blk_d;
  logic [WAY_W-1:0]  set_q, set_d;
  logic [IDX_W-1:0]  base_q, base_d;
  logic [WAY_W:0]    nways_q, nways_d;
  logic [WAY_W:0]    issue_q, issue_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [WAY_W-1:0]  cmp_way_q, cmp_way_d;
  logic              cmp_line_vld_q, cmp_line_vld_d;
  logic              empty_fnd_q, empty_fnd_d;
  logic [WAY_W-1:0]  empty_way_q, empty_way_d;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [CNT_W-1:0]  hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]  miss_cnt_q, miss_cnt_d;
  logic [STORE_DEPTH-1:0] valid_q, valid_d;

  logic             out_vld_q, out_vld_d;
  logic             out_hit_q, out_hit_d;
  logic [WAY_W-1:0] out_way_q, out_way_d;
  logic             out_fill_q, out_fill_d;

  logic [3:0]        boff_eff;
  logic [2:0]        lbits, wbits, sbits;
  logic [WAY_W:0]    set_span, way_span;
  logic [WAY_W-1:0]  set_mask, set_off;
  logic [ADDR_W-1:0] blk_in;
  logic [WAY_W-1:0]  set_in;

  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_data;
  logic              hit_now;
  logic              out_free;
  logic [WAY_W-1:0]  way_mask;
  logic [LFSR_W-1:0] lfsr_step;
  logic [WAY_W-1:0]  victim;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;

  // Geometry of the access, worked out at the address transfer
  always_comb begin
    boff_eff = (boff_q > OFFSET_MAX) ? OFFSET_MAX : boff_q;
    lbits    = (lines_q > LINES_MAX) ? LINES_MAX : lines_q;
    wbits    = (ways_q > lbits) ? lbits : ways_q;
    sbits    = lbits - wbits;
    set_span = (WAY_W+1)'(1) << sbits;
    set_mask = WAY_W'(set_span - (WAY_W+1)'(1));
    way_span = (WAY_W+1)'(1) << wbits;
    blk_in   = req_i.address >> boff_eff;
    set_in   = blk_in[WAY_W-1:0] & set_mask;
    set_off  = WAY_W'(set_in << wbits);
  end

  assign way_mask  = WAY_W'(nways_q - (WAY_W+1)'(1));
  assign rd_addr   = base_q + IDX_W'(issue_q[WAY_W-1:0]);
  assign hit_now   = cmp_vld_q && cmp_line_vld_q && (rd_data == blk_q);
  assign out_free  = !out_vld_q || rsp_o.ready;
  assign lfsr_step = lfsr_next(lfsr_q);
  assign victim    = empty_fnd_q ? empty_way_q : (lfsr_step[WAY_W-1:0] & way_mask);
  assign wr_addr   = base_q + IDX_W'(victim);
  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    blk_d          = blk_q;
    set_d          = set_q;
    base_d         = base_q;
    nways_d        = nways_q;
    issue_d        = issue_q;
    cmp_vld_d      = 1'b0;
    cmp_way_d      = cmp_way_q;
    cmp_line_vld_d = cmp_line_vld_q;
    empty_fnd_d    = empty_fnd_q;
    empty_way_d    = empty_way_q;
    lfsr_d         = lfsr_q;
    hit_cnt_d      = hit_cnt_q;
    miss_cnt_d     = miss_cnt_q;
    valid_d        = valid_q;
    out_vld_d      = out_vld_q && !rsp_o.ready;
    out_hit_d      = out_hit_q;
    out_way_d      = out_way_q;
    out_fill_d     = out_fill_q;
    rd_en          = 1'b0;
    wr_en          = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          blk_d       = blk_in;
          set_d       = set_in;
          base_d      = {req_i.cache_select, set_off};
          nways_d     = way_span;
          issue_d     = '0;
          empty_fnd_d = 1'b0;
          state_d     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit_now) begin
          cmp_vld_d = 1'b1;
          if (out_free) begin
            cmp_vld_d  = 1'b0;
            if (hit_cnt_q != '1) begin
              hit_cnt_d = hit_cnt_q + CNT_W'(1);
            end
            out_vld_d  = 1'b1;
            out_hit_d  = 1'b1;
            out_way_d  = cmp_way_q;
            out_fill_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end else if (issue_q != nways_q) begin
          rd_en          = 1'b1;
          cmp_vld_d      = 1'b1;
          cmp_way_d      = issue_q[WAY_W-1:0];
          cmp_line_vld_d = valid_q[rd_addr];
          if (!valid_q[rd_addr] && !empty_fnd_q) begin
            empty_fnd_d = 1'b1;
            empty_way_d = issue_q[WAY_W-1:0];
          end
          issue_d = issue_q + (WAY_W+1)'(1);
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (out_free) begin
          if (!empty_fnd_q) begin
            lfsr_d = lfsr_step;
          end
          if (miss_cnt_q != '1) begin
            miss_cnt_d = miss_cnt_q + CNT_W'(1);
          end
          wr_en            = 1'b1;
          valid_d[wr_addr] = 1'b1;
          out_vld_d        = 1'b1;
          out_hit_d        = 1'b0;
          out_way_d        = victim;
          out_fill_d       = empty_fnd_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  sacrr_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (STORE_DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (blk_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      boff_q     <= 4'd2;
      lines_q    <= 3'd6;
      ways_q     <= 3'd0;
      cmp_vld_q  <= 1'b0;
      lfsr_q     <= LFSR_SEED;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      valid_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cmp_vld_q  <= cmp_vld_d;
      lfsr_q     <= lfsr_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      valid_q    <= valid_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCK_BYTES_LOG2: boff_q  <= cfg_data_i;
          CFG_LINES_LOG2:       lines_q <= cfg_data_i[2:0];
          CFG_WAYS_LOG2:        ways_q  <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q          <= blk_d;
    set_q          <= set_d;
    base_q         <= base_d;
    nways_q        <= nways_d;
    issue_q        <= issue_d;
    cmp_way_q      <= cmp_way_d;
    cmp_line_vld_q <= cmp_line_vld_d;
    empty_fnd_q    <= empty_fnd_d;
    empty_way_q    <= empty_way_d;
    out_hit_q      <= out_hit_d;
    out_way_q      <= out_way_d;
    out_fill_q     <= out_fill_d;
  end

  // set_q is only ever loaded at the address transfer, so it still holds the
  // current access when the result register is loaded
  logic [WAY_W-1:0] out_set_q;

  always_ff @(posedge clk_i) begin
    if (state_q != ST_IDLE && state_d == ST_IDLE) begin
      out_set_q <= set_q;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.hit          = out_hit_q;
  assign rsp_o.set_index    = out_set_q;
  assign rsp_o.way_used     = out_way_q;
  assign rsp_o.filled_empty = out_fill_q;
  assign rsp_o.hit_total    = hit_cnt_q;
  assign rsp_o.miss_total   = miss_cnt_q;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Tag-model check of the set-associative cache with LFSR victim selection.
// A directed table covers the geometry extremes, register clamping,
// reconfiguration without a flush and both caches. Random phases then run
// address pools under varied geometry and idle patterns. Results are checked
// against an in-bench tag store copy; pinned table rows fix hit, set, way and fill.
// ----------------------------------------------------------------------------
module testbench;
  import sacrr_pkg::*;

  localparam int                   WATCHDOG_LIMIT  = 3000;
  localparam int                   NUM_PHASES      = 8;
  localparam int                   PHASE_ITEMS     = 172;
  localparam int                   HOLD_CYCLES     = 400;
  localparam int                   SETTLE_CYCLES   = 70;
  localparam int                   POOL_MAX        = 96;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 2'd3;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] set_index;
    logic [WAY_W-1:0] way_used;
    logic             filled_empty;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } access_res_t;

  typedef enum bit {ROW_ACC, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [ADDR_W-1:0]     addr;
    logic                  sel;
    bit                    pinned;
    logic                  hit;
    logic [WAY_W-1:0]      set_index;
    logic [WAY_W-1:0]      way_used;
    logic                  filled;
  } drow_t;

  // pinned rows carry hit, set, way and fill flag; totals always come from the tag copy
  localparam drow_t DIR_ROWS [25] = '{
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h0000_0000, 1'b0, 1'b1, 1'b0, 6'd0,  6'd0,  1'b1},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h0000_0003, 1'b0, 1'b1, 1'b1, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 6'd63, 6'd0,  1'b1},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd63, 6'd0,  1'b1},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'hFFFF_FFFC, 1'b1, 1'b1, 1'b1, 6'd63, 6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h0000_0100, 1'b0, 1'b1, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h0000_0000, 1'b0, 1'b1, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h8000_0004, 1'b1, 1'b1, 1'b0, 6'd1,  6'd0,  1'b1},
    '{ROW_CFG, CFG_UNUSED,           4'hF,  32'h0,         1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_CFG, CFG_WAYS_LOG2,        4'd7,  32'h0,         1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h1234_5678, 1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd0,  6'd63, 1'b0},
    '{ROW_CFG, CFG_BLOCK_BYTES_LOG2, 4'd15, 32'h0,         1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'hFFFF_F000, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_CFG, CFG_LINES_LOG2,       4'd7,  32'h0,         1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h0000_0FFF, 1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h5A5A_A5A5, 1'b1, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_CFG, CFG_LINES_LOG2,       4'd0,  32'h0,         1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_CFG, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h0,         1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h0000_0001, 1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_ACC, CFG_BLOCK_BYTES_LOG2, 4'd0,  32'h0000_0002, 1'b0, 1'b1, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_CFG, CFG_BLOCK_BYTES_LOG2, 4'd2,  32'h0,         1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_CFG, CFG_LINES_LOG2,       4'd6,  32'h0,         1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0},
    '{ROW_CFG, CFG_WAYS_LOG2,        4'd0,  32'h0,         1'b0, 1'b0, 1'b0, 6'd0,  6'd0,  1'b0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sacrr_req_if req_if ();
  sacrr_rsp_if rsp_if ();

  set_assoc_cache_random_replace_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // tag store copy and geometry registers
  bit                    tag_valid [STORE_DEPTH];
  logic [ADDR_W-1:0]     tag_block [STORE_DEPTH];
  logic [LFSR_W-1:0]     victim_lfsr;
  logic [CNT_W-1:0]      hits_seen;
  logic [CNT_W-1:0]      misses_seen;
  logic [3:0]            cfg_offset_bits;
  logic [2:0]            cfg_lines_bits;
  logic [2:0]            cfg_ways_bits;

  access_res_t           pending_results [$];
  int                    mismatches     = 0;
  int                    snd_idle_pct   = 0;
  int                    rcv_stall_pct  = 0;
  int                    phase_no       = -1;
  int                    stall_count    = 0;
  bit                    hold_rsp       = 1'b0;
  logic [ADDR_W-1:0]     block_pool [POOL_MAX];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic access_res_t lookup_and_fill(input logic [ADDR_W-1:0] addr,
                                                  input logic sel);
    access_res_t       r;
    int unsigned       boff, lbits, wbits, nways, nsets, base, w, way_no;
    logic [ADDR_W-1:0] blk, set_no;
    bit                found, fresh;
    r      = '0;
    found  = 1'b0;
    fresh  = 1'b0;
    way_no = 0;
    boff   = (cfg_offset_bits > OFFSET_MAX) ? OFFSET_MAX : cfg_offset_bits;
    lbits  = (cfg_lines_bits > LINES_MAX) ? LINES_MAX : cfg_lines_bits;
    wbits  = (cfg_ways_bits > lbits) ? lbits : cfg_ways_bits;
    nways  = 1 << wbits;
    nsets  = 1 << (lbits - wbits);
    blk    = addr >> boff;
    set_no = blk & (nsets - 1);
    base   = sel * MAX_LINES + set_no * nways;
    for (w = 0; w < nways && !found; w++) begin
      if (tag_valid[base + w] && tag_block[base + w] == blk) begin
        found  = 1'b1;
        way_no = w;
      end
    end
    if (found) begin
      if (hits_seen != '1) hits_seen++;
    end else begin
      if (misses_seen != '1) misses_seen++;
      for (w = 0; w < nways && !fresh; w++) begin
        if (!tag_valid[base + w]) begin
          fresh  = 1'b1;
          way_no = w;
        end
      end
      if (!fresh) begin
        victim_lfsr = (victim_lfsr >> 1) ^ (victim_lfsr[0] ? LFSR_TAPS : '0);
        way_no      = victim_lfsr & (nways - 1);
      end
      tag_valid[base + way_no] = 1'b1;
      tag_block[base + way_no] = blk;
    end
    r.hit          = found;
    r.set_index    = set_no[WAY_W-1:0];
    r.way_used     = way_no[WAY_W-1:0];
    r.filled_empty = !found && fresh;
    r.hit_total    = hits_seen;
    r.miss_total   = misses_seen;
    return r;
  endfunction

  // the task lowers the enable and waits with it low before returning, so back-to-back writes never collide
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_BLOCK_BYTES_LOG2: cfg_offset_bits = val;
      CFG_LINES_LOG2:       cfg_lines_bits  = val[2:0];
      CFG_WAYS_LOG2:        cfg_ways_bits   = val[2:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic issue_access(input logic [ADDR_W-1:0] addr, input logic sel,
                              input drow_t pin);
    int          gap;
    access_res_t res;
    gap = 0;
    while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.address      <= addr;
    req_if.cache_select <= sel;
    do @(posedge clk_i); while (!req_if.ready);
    res = lookup_and_fill(addr, sel);
    if (pin.pinned) begin
      res.hit          = pin.hit;
      res.set_index    = pin.set_index;
      res.way_used     = pin.way_used;
      res.filled_empty = pin.filled;
    end
    pending_results = {pending_results, res};
  endtask

  always @(posedge clk_i) begin : rsp_side
    access_res_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result transfer: expected none, got hit %0d way %0d",
                   $time, rsp_if.hit, rsp_if.way_used);
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.hit !== want.hit) begin
            mismatches++;
            $display("%0t hit: expected %0d, got %0d", $time, want.hit, rsp_if.hit);
          end
          if (rsp_if.set_index !== want.set_index) begin
            mismatches++;
            $display("%0t set_index: expected %0d, got %0d",
                     $time, want.set_index, rsp_if.set_index);
          end
          if (rsp_if.way_used !== want.way_used) begin
            mismatches++;
            $display("%0t way_used: expected %0d, got %0d",
                     $time, want.way_used, rsp_if.way_used);
          end
          if (rsp_if.filled_empty !== want.filled_empty) begin
            mismatches++;
            $display("%0t filled_empty: expected %0d, got %0d",
                     $time, want.filled_empty, rsp_if.filled_empty);
          end
          if (rsp_if.hit_total !== want.hit_total) begin
            mismatches++;
            $display("%0t hit_total: expected %0d, got %0d",
                     $time, want.hit_total, rsp_if.hit_total);
          end
          if (rsp_if.miss_total !== want.miss_total) begin
            mismatches++;
            $display("%0t miss_total: expected %0d, got %0d",
                     $time, want.miss_total, rsp_if.miss_total);
          end
        end
      end
      rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // long output hold-off so the block backs up and refuses new transfers
  initial begin
    wait (phase_no == 2);
    repeat (20) @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
        || cfg_we_i) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("%0t no transfer for %0d cycles", $time, stall_count);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int                  pool_size, mode;
    int unsigned         boff;
    logic [ADDR_W-1:0]   offmask, addr;
    logic [CFG_DATA_W-1:0] v_off, v_lines, v_ways;
    rst_ni              = 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= '0;
    cfg_data_i          <= '0;
    req_if.valid        <= 1'b0;
    req_if.address      <= '0;
    req_if.cache_select <= 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      tag_valid[i] = 1'b0;
      tag_block[i] = '0;
    end
    victim_lfsr     = LFSR_SEED;
    hits_seen       = '0;
    misses_seen     = '0;
    cfg_offset_bits = 4'd2;
    cfg_lines_bits  = 3'd6;
    cfg_ways_bits   = 3'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].reg_val);
      end else begin
        issue_access(DIR_ROWS[i].addr, DIR_ROWS[i].sel, DIR_ROWS[i]);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0:       begin v_off = 4'd0;  v_lines = 4'd0; v_ways = 4'd0; end
        1:       begin v_off = 4'd12; v_lines = 4'd6; v_ways = 4'd6; end
        2:       begin v_off = 4'd15; v_lines = 4'd7; v_ways = 4'd7; end
        3:       begin v_off = 4'd2;  v_lines = 4'd6; v_ways = 4'd0; end
        default: begin
          v_off   = $urandom_range(15);
          v_lines = $urandom_range(15);
          v_ways  = $urandom_range(15);
        end
      endcase
      write_reg(CFG_BLOCK_BYTES_LOG2, v_off);
      write_reg(CFG_LINES_LOG2, v_lines);
      write_reg(CFG_WAYS_LOG2, v_ways);
      mode = p % 4;
      snd_idle_pct   = (mode == 1) ? 51 : (mode == 3) ? 37 : 0;
      rcv_stall_pct <= (mode == 2) ? 51 : (mode == 3) ? 37 : 0;
      phase_no       = p;
      boff      = (cfg_offset_bits > OFFSET_MAX) ? OFFSET_MAX : cfg_offset_bits;
      offmask   = (32'd1 << boff) - 32'd1;
      pool_size = $urandom_range(POOL_MAX, 4);
      for (int k = 0; k < pool_size; k++) block_pool[k] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) == 0) wait_drained();
        if ($urandom_range(99) < 75) begin
          addr = block_pool[$urandom_range(pool_size - 1)] ^ ($urandom & offmask);
        end else begin
          addr = $urandom;
        end
        issue_access(addr, $urandom_range(1), '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t %0d results never arrived", $time, pending_results.size());
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### set_assoc_cache_random_replace_top.f
rtl/sacrr_pkg.sv
rtl/sacrr_req_if.sv
rtl/sacrr_rsp_if.sv
rtl/sacrr_ram.sv
rtl/set_assoc_cache_random_replace_top.sv
test/testbench.sv
